// File: rtl/alf_pkg.sv
// shared types, constants and tables for the adc to lux float encoder
package alf_pkg;

  // saturation and float packing constants
  localparam logic [7:0]  SAT_HIGH_BYTE = 8'd112;
  localparam logic [15:0] SAT_LUX       = 16'hFFFF;
  localparam logic [3:0]  EXP_START     = 4'd7;
  localparam logic [15:0] MANT_MAX      = 16'h07FF;
  localparam logic [3:0]  SEG_LAST      = 4'd14;
  localparam logic [3:0]  SEG_FINE      = 4'd11;
  localparam logic [3:0]  SEG_LOW_TERM  = 4'd7;

  // divider operand select codes
  localparam logic [1:0] DIV_OP_INTERP = 2'd0;
  localparam logic [1:0] DIV_OP_LOW    = 2'd1;
  localparam logic [1:0] DIV_OP_THR    = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;
    logic       walk_step;
    logic       set_sat;
    logic       div_start;
    logic [1:0] div_op;
    logic       add_interp;
    logic       add_low;
    logic       mant_init;
    logic       norm_step;
    logic       finish;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic sat;
    logic walk_more;
    logic seg_low;
    logic div_busy;
    logic mant_big;
    logic out_free;
  } dp_stat_t;

  // breakpoint table of the high byte
  function automatic logic [7:0] brk(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'd0;
      4'd1:    v = 8'd9;
      4'd2:    v = 8'd17;
      4'd3:    v = 8'd27;
      4'd4:    v = 8'd40;
      4'd5:    v = 8'd53;
      4'd6:    v = 8'd66;
      4'd7:    v = 8'd79;
      4'd8:    v = 8'd88;
      4'd9:    v = 8'd96;
      4'd10:   v = 8'd101;
      4'd11:   v = 8'd106;
      4'd12:   v = 8'd109;
      4'd13:   v = 8'd112;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  // relative change divisor, selectors above four act as four
  function automatic logic [6:0] step_div(input logic [2:0] sel);
    logic [6:0] v;
    case (sel)
      3'd0:    v = 7'd100;
      3'd1:    v = 7'd20;
      3'd2:    v = 7'd10;
      3'd3:    v = 7'd5;
      default: v = 7'd3;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/alf_if.sv
// valid/ready channel interfaces of the encoder

// conversion input channel
interface alf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] adc_high;
  logic [7:0] adc_low;
  modport source (output valid, adc_high, adc_low, input ready);
  modport sink (input valid, adc_high, adc_low, output ready);
endinterface

// result channel
interface alf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] lux_value;
  logic [15:0] float_code;
  logic        object_updated;
  logic        send_now;
  modport source (output valid, lux_value, float_code, object_updated, send_now,
                  input ready);
  modport sink (input valid, lux_value, float_code, object_updated, send_now,
                output ready);
endinterface

// configuration write channel
interface alf_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] change_step_select;
  modport source (output valid, change_step_select, input ready);
  modport sink (input valid, change_step_select, output ready);
endinterface

// File: rtl/adc_to_lux_float_encoder_unit.sv
// top level of the adc to lux float encoder
//
// in_ch carries one light-sensor conversion (adc_high, adc_low) per transfer.
// out_ch returns exactly one result per conversion: lux_value, float_code,
// object_updated and send_now. cfg_ch writes change_step_select (always ready);
// write it only while no conversion is in flight.
// From transfer in to posting the result, an item goes through a segment walk
// over the breakpoint table, then up to three runs of the shared bit-serial
// divider (interpolation, low-byte term for the lower octaves, change
// threshold), the mantissa normalization overlapping the last division, and
// the posting step. A saturated high byte skips the walk and the first two
// divisions. One conversion is worked on at a time; in_ch.ready is high only
// when the controller is idle, in the cycle after posting, so a new conversion
// is not taken before the last one is posted.
// The result sits in an output register, so the next conversion is taken and
// computed while a result waits; if the receiver still stalls when the next
// result is ready, the controller holds it until the register is free.
// A synchronous active-low reset clears the last sent value and the selector
// to zero and empties the output register.
module adc_to_lux_float_encoder_unit (
  input  logic      clk,
  input  logic      rst_n,
  alf_in_if.sink    in_ch,
  alf_out_if.source out_ch,
  alf_cfg_if.sink   cfg_ch
);

  alf_pkg::dp_cmd_t  cmd;
  alf_pkg::dp_stat_t stat;
  logic              in_ready;

  assign in_ch.ready = in_ready;

  alf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  alf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .adc_high (in_ch.adc_high),
    .adc_low  (in_ch.adc_low),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_ch   (cfg_ch),
    .out_ch   (out_ch)
  );

endmodule

// File: rtl/alf_div.sv
// restoring divider, 16-bit dividend by 7-bit divisor, one bit per cycle
module alf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [6:0]  divisor,
  output logic        busy,
  output logic [15:0] quotient
);

  logic        busy_r, busy_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [6:0]  dsr_r, dsr_nxt;
  logic [7:0]  trial;
  logic        ge;

  // one trial subtraction per cycle
  assign trial = {rem_r, quo_r[15]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd15;
      rem_nxt  = 7'd0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? 7'(trial - {1'b0, dsr_r}) : trial[6:0];
      quo_nxt = {quo_r[14:0], ge};
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// File: rtl/alf_dp.sv
// datapath: segment walk, interpolation, float packing, send-on-change, output register
module alf_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        adc_high,
  input  logic [7:0]        adc_low,
  input  alf_pkg::dp_cmd_t  cmd,
  output alf_pkg::dp_stat_t stat,
  alf_cfg_if.sink           cfg_ch,
  alf_out_if.source         out_ch
);

  logic [7:0]  hi_r, lo_r;
  logic [3:0]  seg_r, seg_nxt;
  logic [15:0] lux_r, lux_nxt;
  logic [15:0] mant_r, mant_nxt;
  logic [3:0]  exp_r, exp_nxt;
  logic [15:0] last_r, last_nxt;
  logic [2:0]  sel_r;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_lux_r, out_code_r;
  logic        out_upd_r, out_send_r;

  logic [7:0]  bp_lo, bp_hi;
  logic [3:0]  delta;
  logic [7:0]  rest;
  logic [3:0]  sh;
  logic [15:0] dvd;
  logic [6:0]  dsr;
  logic        div_busy;
  logic [15:0] quo;
  logic [15:0] base;
  logic [15:0] thr, diff;
  logic        send;

  // segment bounds around the current octave
  assign bp_lo = alf_pkg::brk(4'(seg_r - 4'd1));
  assign bp_hi = alf_pkg::brk(seg_r);
  assign delta = 4'(bp_hi - bp_lo);
  assign rest  = hi_r - bp_lo;
  assign sh    = (seg_r < alf_pkg::SEG_FINE) ? 4'(seg_r + 4'd2) : 4'(seg_r - 4'd2);

  // divider operand selection
  always_comb begin
    case (cmd.div_op)
      alf_pkg::DIV_OP_INTERP: begin
        dvd = {8'd0, rest} << sh;
        dsr = {3'd0, delta};
      end
      alf_pkg::DIV_OP_LOW: begin
        dvd = {8'd0, lo_r} << 4'(seg_r + 4'd2);
        dsr = {3'd0, delta};
      end
      alf_pkg::DIV_OP_THR: begin
        dvd = last_r;
        dsr = alf_pkg::step_div(sel_r);
      end
      default: begin
        dvd = last_r;
        dsr = alf_pkg::step_div(sel_r);
      end
    endcase
  end

  alf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .busy     (div_busy),
    .quotient (quo)
  );

  // octave base value, the first segment starts at zero
  assign base = (seg_r == 4'd1) ? 16'd0 : (16'd2 << seg_r);

  // send-on-change decision from the threshold quotient
  assign thr  = (quo == 16'd0) ? 16'd1 : quo;
  assign diff = (lux_r > last_r) ? 16'(lux_r - last_r) : 16'(last_r - lux_r);
  assign send = (sel_r != 3'd0) && (diff >= thr);

  always_comb begin
    seg_nxt       = seg_r;
    lux_nxt       = lux_r;
    mant_nxt      = mant_r;
    exp_nxt       = exp_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load) begin
      seg_nxt = 4'd0;
    end
    if (cmd.walk_step) begin
      seg_nxt = 4'(seg_r + 4'd1);
    end
    if (cmd.set_sat) begin
      lux_nxt = alf_pkg::SAT_LUX;
    end
    if (cmd.add_interp) begin
      lux_nxt = (seg_r < alf_pkg::SEG_FINE) ? 16'(base + quo) : 16'(base + (quo << 4));
    end
    if (cmd.add_low) begin
      lux_nxt = 16'(lux_r + (quo >> 8));
    end
    // scale by one half plus one quarter plus one thirty-second
    if (cmd.mant_init) begin
      mant_nxt = 16'({1'b0, lux_r[15:1]} + {2'b0, lux_r[15:2]} + {5'b0, lux_r[15:5]});
      exp_nxt  = alf_pkg::EXP_START;
    end
    if (cmd.norm_step) begin
      mant_nxt = mant_r >> 1;
      exp_nxt  = 4'(exp_r + 4'd1);
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      if (send) begin
        last_nxt = lux_r;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= 16'd0;
      sel_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        sel_r <= cfg_ch.change_step_select;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hi_r <= adc_high;
      lo_r <= adc_low;
    end
    seg_r  <= seg_nxt;
    lux_r  <= lux_nxt;
    mant_r <= mant_nxt;
    exp_r  <= exp_nxt;
    if (cmd.finish) begin
      out_lux_r  <= lux_r;
      out_code_r <= {1'b0, exp_r, mant_r[10:0]};
      out_upd_r  <= lux_r != last_r;
      out_send_r <= send;
    end
  end

  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.lux_value      = out_lux_r;
  assign out_ch.float_code     = out_code_r;
  assign out_ch.object_updated = out_upd_r;
  assign out_ch.send_now       = out_send_r;

  assign stat.sat       = hi_r >= alf_pkg::SAT_HIGH_BYTE;
  assign stat.walk_more = (seg_r < alf_pkg::SEG_LAST) && (hi_r >= bp_hi);
  assign stat.seg_low   = seg_r < alf_pkg::SEG_LOW_TERM;
  assign stat.div_busy  = div_busy;
  assign stat.mant_big  = mant_r > alf_pkg::MANT_MAX;
  assign stat.out_free  = !out_valid_r || out_ch.ready;

`ifndef ASSERT_OFF
  // a result is never written over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten before transfer");

  // the divider is only started when idle
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  // normalization only shifts an oversized mantissa
  a_norm_needed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.norm_step |-> (mant_r > alf_pkg::MANT_MAX))
    else $error("normalization step on a fitting mantissa");

  // a posted result is marked valid and carries no sign
  a_code_form: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_valid_r && !out_code_r[15]))
    else $error("posted float code malformed");
`endif

endmodule

// File: rtl/alf_ctrl.sv
// controller state machine sequencing the encoder datapath
module alf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  alf_pkg::dp_stat_t stat,
  output alf_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_THR  = 3'd4;
  localparam logic [2:0] S_DIVT = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_op = alf_pkg::DIV_OP_INTERP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.sat) begin
          cmd.set_sat = 1'b1;
          state_nxt   = S_THR;
        end else if (stat.walk_more) begin
          cmd.walk_step = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = alf_pkg::DIV_OP_INTERP;
          state_nxt     = S_DIV1;
        end
      end
      S_DIV1: begin
        if (!stat.div_busy) begin
          cmd.add_interp = 1'b1;
          if (stat.seg_low) begin
            cmd.div_start = 1'b1;
            cmd.div_op    = alf_pkg::DIV_OP_LOW;
            state_nxt     = S_DIV2;
          end else begin
            state_nxt = S_THR;
          end
        end
      end
      S_DIV2: begin
        if (!stat.div_busy) begin
          cmd.add_low = 1'b1;
          state_nxt   = S_THR;
        end
      end
      S_THR: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = alf_pkg::DIV_OP_THR;
        cmd.mant_init = 1'b1;
        state_nxt     = S_DIVT;
      end
      // normalization runs alongside the threshold division
      S_DIVT: begin
        cmd.norm_step = stat.mant_big;
        if (!stat.div_busy && !stat.mant_big) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a transfer in always starts the segment walk
  a_load_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_WALK))
    else $error("accepted conversion did not start the walk");

  // the result is posted only from the output state
  a_finish_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (state_r == S_OUT && stat.out_free))
    else $error("result posted outside the output state");

  // the state register only holds defined codes
  a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r <= S_OUT)
    else $error("controller in an undefined state");
`endif

endmodule

// File: sim/lux_encoder_checker.sv
`timescale 1ns / 1ps
// lux encoder result checker: predicts each conversion and compares the result transfers
module lux_encoder_checker (
  input  logic clk,
  input  logic rst_n,
  alf_in_if    in_ch,
  alf_out_if   out_ch,
  alf_cfg_if   cfg_ch,
  output int   mismatches,
  output int   results_due
);

  // selector codes
  localparam logic [2:0] SEL_OFF = 3'd0;
  localparam logic [2:0] SEL_TOP = 3'd4;

  // octave breakpoints of the high byte and relative change divisors
  localparam logic [7:0] OCTAVE_EDGE [15] = '{8'd0, 8'd9, 8'd17, 8'd27, 8'd40, 8'd53,
    8'd66, 8'd79, 8'd88, 8'd96, 8'd101, 8'd106, 8'd109, 8'd112, 8'd255};
  localparam logic [6:0] CHANGE_DIV [5] = '{7'd100, 7'd20, 7'd10, 7'd5, 7'd3};

  typedef struct packed {
    logic [15:0] lux;
    logic [15:0] code;
    logic        updated;
    logic        send;
  } lux_result_t;

  lux_result_t lux_results_due [$];
  lux_result_t want;
  logic [2:0]  step_sel;
  logic [15:0] last_sent;

  // octave walk plus interpolation inside the segment
  function automatic logic [15:0] lux_from_adc(input logic [7:0] hi, input logic [7:0] lo);
    int unsigned seg;
    int unsigned acc;
    int unsigned rest;
    int unsigned span;
    int unsigned sh;
    int unsigned lo_w;
    if (hi >= alf_pkg::SAT_HIGH_BYTE) return alf_pkg::SAT_LUX;
    seg = 0;
    acc = 2;
    lo_w = lo;
    while (seg < 14 && hi >= OCTAVE_EDGE[seg]) begin
      seg++;
      acc = acc << 1;
    end
    if (seg <= 1) acc = 0;
    rest = hi - OCTAVE_EDGE[seg - 1];
    span = OCTAVE_EDGE[seg] - OCTAVE_EDGE[seg - 1];
    sh = (seg < 11) ? seg + 2 : seg - 2;
    rest = ((rest << sh) & 32'hFFFF) / span;
    acc += (seg < 11) ? rest : (rest << 4);
    // low byte only refines the lower octaves
    if (seg < 7) acc += (((lo_w << (seg + 2)) & 32'hFFFF) / span) >> 8;
    return 16'(acc);
  endfunction

  // scale by 0.78125 and normalize into an 11-bit mantissa
  function automatic logic [15:0] pack_lux_float(input logic [15:0] lux);
    logic [3:0]  expo;
    int unsigned mant;
    int unsigned lux_w;
    lux_w = lux;
    expo = alf_pkg::EXP_START;
    mant = (lux_w >> 1) + (lux_w >> 2) + (lux_w >> 5);
    while (mant > alf_pkg::MANT_MAX) begin
      mant = mant >> 1;
      expo++;
    end
    return {1'b0, expo, mant[10:0]};
  endfunction

  // full result of one conversion, updates the last sent value on a send
  function automatic lux_result_t predict_conversion(input logic [7:0] hi,
                                                     input logic [7:0] lo);
    lux_result_t r;
    logic [2:0]  sel;
    int unsigned thr;
    int unsigned diff;
    r.lux = lux_from_adc(hi, lo);
    r.code = pack_lux_float(r.lux);
    r.updated = (r.lux != last_sent);
    r.send = 1'b0;
    if (step_sel != SEL_OFF) begin
      sel = (step_sel > SEL_TOP) ? SEL_TOP : step_sel;
      thr = last_sent / CHANGE_DIV[sel];
      diff = (r.lux > last_sent) ? r.lux - last_sent : last_sent - r.lux;
      if (thr == 0) thr = 1;
      if (diff >= thr) begin
        r.send = 1'b1;
        last_sent = r.lux;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      step_sel = SEL_OFF;
      last_sent = '0;
      lux_results_due.delete();
    end else begin
      // result transfer against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (lux_results_due.size() == 0) begin
          $error("result transfer with nothing expected: lux_value %0d", out_ch.lux_value);
          mismatches++;
        end else begin
          want = lux_results_due.pop_front();
          check_field("lux_value", want.lux, out_ch.lux_value);
          check_field("float_code", want.code, out_ch.float_code);
          check_field("object_updated", want.updated, out_ch.object_updated);
          check_field("send_now", want.send, out_ch.send_now);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) step_sel = cfg_ch.change_step_select;
      if (in_ch.valid && in_ch.ready)
        lux_results_due.push_back(predict_conversion(in_ch.adc_high, in_ch.adc_low));
    end
    results_due <= lux_results_due.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, conversion stimulus, receiver stalls and verdict
module tb_top;

  localparam int RUN_LIMIT_NS = 10_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int DIRECTED_AT_RESET = 4;

  // selector settings used across the run
  localparam logic [2:0] SEL_DIV20 = 3'd1;
  localparam logic [2:0] SEL_DIV10 = 3'd2;
  localparam logic [2:0] SEL_DIV5  = 3'd3;
  localparam logic [2:0] SEL_DIV3  = 3'd4;
  localparam logic [2:0] SEL_OFF   = 3'd0;
  localparam logic [2:0] SEL_ALIAS5 = 3'd5;
  localparam logic [2:0] SEL_ALIAS6 = 3'd6;
  localparam logic [2:0] SEL_ALIAS7 = 3'd7;

  // directed conversions {adc_high, adc_low}; the first ones run with send on change off
  localparam logic [15:0] DIRECTED [24] = '{
    16'h0000, 16'h00FF, 16'h3C4D, 16'h3C4D,
    16'h0000, 16'h08FF, 16'h08FF, 16'h0900, 16'h10FF, 16'h1100, 16'h1B80, 16'h2801,
    16'h35FE, 16'h4200, 16'h4FFF, 16'h5800, 16'h60AA, 16'h6555, 16'h6A00, 16'h6DFF,
    16'h6FFF, 16'h7000, 16'hFFFF, 16'h0000};

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   results_due;
  int   tx_idle_pct = 15;
  int   rx_idle_pct = 73;
  int   walk_hi = 50;
  int   walk_lo = 128;

  alf_in_if  in_ch ();
  alf_out_if out_ch ();
  alf_cfg_if cfg_ch ();

  adc_to_lux_float_encoder_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lux_encoder_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // one conversion transfer, entered and left at a falling edge
  task automatic push_conversion(input logic [7:0] hi, input logic [7:0] lo);
    in_ch.valid <= 1'b1;
    in_ch.adc_high <= hi;
    in_ch.adc_low <= lo;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // wait until every predicted result has been taken
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic write_step_select(input logic [2:0] sel);
    cfg_ch.valid <= 1'b1;
    cfg_ch.change_step_select <= sel;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly slow drift around the last value so send on change sees small steps,
  // plus repeats, saturation, uniform picks below saturation and full-range noise
  task automatic next_sample(output logic [7:0] hi, output logic [7:0] lo);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      walk_hi = walk_hi + int'($urandom_range(0, 4)) - 2;
      walk_lo = walk_lo + int'($urandom_range(0, 40)) - 20;
      if (walk_hi < 0) walk_hi = 0;
      if (walk_hi > 115) walk_hi = 115;
      if (walk_lo < 0) walk_lo = 0;
      if (walk_lo > 255) walk_lo = 255;
    end else if (pick < 55) begin
      walk_hi = $urandom_range(112, 255);
      walk_lo = $urandom_range(0, 255);
    end else if (pick < 62) begin
      walk_hi = $urandom_range(0, 255);
      walk_lo = $urandom_range(0, 255);
    end else if (pick < 85) begin
      walk_hi = $urandom_range(0, 111);
      walk_lo = $urandom_range(0, 255);
    end
    // remaining picks repeat the previous conversion
    hi = walk_hi[7:0];
    lo = walk_lo[7:0];
  endtask

  task automatic run_random(input logic [2:0] sel, input int tx_pct, input int rx_pct,
                            input int count);
    logic [7:0] hi;
    logic [7:0] lo;
    settle();
    write_step_select(sel);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) begin
      next_sample(hi, lo);
      sender_gap();
      push_conversion(hi, lo);
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.adc_high = '0;
    in_ch.adc_low = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.change_step_select = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset selector first, then every octave edge with divisor 20
    for (int i = 0; i < 24; i++) begin
      if (i == DIRECTED_AT_RESET) begin
        settle();
        write_step_select(SEL_DIV20);
      end
      sender_gap();
      push_conversion(DIRECTED[i][15:8], DIRECTED[i][7:0]);
    end

    // sender mostly busy, receiver mostly stalled
    run_random(SEL_DIV20, 15, 73, 200);
    run_random(SEL_ALIAS7, 15, 73, 150);
    run_random(SEL_OFF, 15, 73, 150);
    // sender mostly idle, receiver mostly ready
    run_random(SEL_DIV3, 73, 15, 200);
    run_random(SEL_ALIAS5, 73, 15, 150);
    run_random(SEL_DIV10, 73, 15, 150);
    // back to back
    run_random(SEL_DIV5, 0, 0, 200);
    run_random(SEL_ALIAS6, 0, 0, 200);
    run_random(SEL_DIV10, 0, 0, 250);

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
rtl/alf_pkg.sv
rtl/alf_if.sv
rtl/alf_div.sv
rtl/alf_dp.sv
rtl/alf_ctrl.sv
rtl/adc_to_lux_float_encoder_unit.sv
sim/lux_encoder_checker.sv
sim/tb_top.sv
